// ===== hw/rtl/md5_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables for the MD5 digest engine.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam logic [1:0] OP_ABSORB = 2'd0;
  localparam logic [1:0] OP_ABSORB_FINISH = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam int BLOCK_BYTES = 64;
  localparam int LEN_OFFSET = 56;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
  } md5_out_t;

  // controller to datapath
  typedef struct packed {
    logic       wr_en;
    logic [5:0] wr_addr;
    logic [7:0] wr_data;
    logic       start;
    logic       reinit;
  } md5_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md5_sts_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return k[i];
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s [16];
    s = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return s[{i[5:4], i[1:0]}];
  endfunction

  // message word index per round
  function automatic logic [3:0] round_g(input logic [5:0] i);
    logic [3:0] l;
    l = i[3:0];
    case (i[5:4])
      2'd0: return l;
      2'd1: return 4'(5 * l + 1);
      2'd2: return 4'(3 * l + 5);
      default: return 4'(7 * l);
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/md5_digest_engine_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5_digest_engine_core
// MD5 digest of a byte stream, one byte per input word.
// ----------------------------------------------------------------------------
// Input words carry op and data_byte; op 0 absorbs, 1 absorbs then finishes,
// 2 finishes only, 3 is dropped. A byte with op 0 that does not fill a block
// leaves in_stall low. The 64th byte of a block starts the round unit: 64
// rounds, one per cycle, then the chaining add; in_stall stays high and no
// byte is taken until the block is done.
// A finish writes the padding bytes one per cycle into the block buffer and
// runs one or two padding blocks, then holds the digest on out_data with
// out_valid high until out_stall is low; no new word is taken meanwhile.
// After delivery the chaining words return to their initial values.
// Reset (rst_n low, synchronous) clears the sequencer, counts and chaining
// words; the block buffer needs no clearing.
// ----------------------------------------------------------------------------
module md5_digest_engine_core import md5_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire md5_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output md5_out_t     out_data
);

  md5_cmd_t cmd;
  md5_sts_t sts;

  md5_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .cmd, .sts
  );

  md5_dp u_dp (.clk, .rst_n, .cmd, .sts, .digest(out_data));

  a_no_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> !cmd.wr_en) else $error("block write during rounds");
  a_no_take_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken with digest pending");
  a_no_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !sts.busy) else $error("digest shown mid compression");

endmodule
`default_nettype wire

// ===== hw/rtl/md5_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer: takes bytes, writes them into the block, drives padding and
// length, starts compressions and hands the digest out.
// ----------------------------------------------------------------------------
module md5_ctrl import md5_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire md5_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output md5_cmd_t      cmd,
  input  wire md5_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMP = 3'd1;  // full block compressing
  localparam logic [2:0] S_PAD  = 3'd2;  // writing pad/zero/length bytes
  localparam logic [2:0] S_PCMP = 3'd3;  // padding block compressing
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] total_r, total_nxt;
  logic        fin_r, fin_nxt;     // finish after current full block
  logic        last_r, last_nxt;   // padding block holds the length
  logic        started_r, started_nxt;
  logic        acc;
  logic [63:0] bits;
  logic [5:0]  len_sel;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign acc = in_valid && !in_stall;
  assign bits = {total_r[60:0], 3'b000};
  assign len_sel = fill_r - 6'(LEN_OFFSET);

  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r;
    total_nxt = total_r;
    fin_nxt = fin_r;
    last_nxt = last_r;
    started_nxt = 1'b0;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_data.op == OP_ABSORB || in_data.op == OP_ABSORB_FINISH) begin
            cmd.wr_en = 1'b1;
            cmd.wr_addr = fill_r;
            cmd.wr_data = in_data.data_byte;
            total_nxt = total_r + 64'd1;
            fill_nxt = fill_r + 6'd1;
            fin_nxt = (in_data.op == OP_ABSORB_FINISH);
            if (fill_r == 6'd63) begin
              cmd.start = 1'b1;
              state_nxt = S_COMP;
            end else if (in_data.op == OP_ABSORB_FINISH) begin
              state_nxt = S_PAD;
              fin_nxt = 1'b0;
            end
          end else if (in_data.op == OP_FINISH) begin
            state_nxt = S_PAD;
          end
          // pad byte goes first on entry to S_PAD
          started_nxt = 1'b1;
        end
      end
      S_COMP: begin
        if (sts.done) begin
          state_nxt = fin_r ? S_PAD : S_IDLE;
          started_nxt = 1'b1;
          fin_nxt = 1'b0;
        end
      end
      S_PAD: begin
        cmd.wr_en = 1'b1;
        cmd.wr_addr = fill_r;
        fill_nxt = fill_r + 6'd1;
        if (started_r) cmd.wr_data = PAD_BYTE;
        else if (last_r && fill_r >= 6'(LEN_OFFSET))
          cmd.wr_data = bits[len_sel[2:0]*8 +: 8];
        else cmd.wr_data = 8'h00;
        if (started_r && fill_r >= 6'(LEN_OFFSET)) last_nxt = 1'b0;
        else if (started_r) last_nxt = 1'b1;
        if (fill_r == 6'd63) begin
          cmd.start = 1'b1;
          state_nxt = S_PCMP;
        end
      end
      S_PCMP: begin
        if (sts.done) state_nxt = last_r ? S_OUT : S_PAD;
        if (sts.done && !last_r) last_nxt = 1'b1;
      end
      S_OUT: begin
        if (!out_stall) begin
          cmd.reinit = 1'b1;
          state_nxt = S_IDLE;
          fill_nxt = '0;
          total_nxt = '0;
          last_nxt = 1'b0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      total_r <= '0;
      fin_r <= 1'b0;
      last_r <= 1'b0;
      started_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      total_r <= total_nxt;
      fin_r <= fin_nxt;
      last_r <= last_nxt;
      started_r <= started_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/md5_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5_dp
// Block buffer, one-round-per-cycle compression unit and chaining words.
// ----------------------------------------------------------------------------
module md5_dp import md5_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire md5_cmd_t cmd,
  output md5_sts_t      sts,
  output md5_out_t      digest
);

  logic [31:0] wbuf_r [16];
  logic [31:0] h_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  rnd_r;
  logic        busy_r, done_r;
  logic [31:0] f, t, rot, w;
  logic [5:0]  rnd;

  assign rnd = rnd_r;
  assign w = wbuf_r[round_g(rnd)];

  always_comb begin
    case (rnd[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    t = a_r + f + w + round_k(rnd);
    rot = (t << round_s(rnd)) | (t >> (6'd32 - {1'b0, round_s(rnd)}));
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en)
      wbuf_r[cmd.wr_addr[5:2]][cmd.wr_addr[1:0]*8 +: 8] <= cmd.wr_data;
    if (cmd.start) begin
      a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
    end else if (busy_r) begin
      a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_r + rot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r <= '0;
      h_r <= '{IV_A, IV_B, IV_C, IV_D};
    end else begin
      done_r <= 1'b0;
      if (cmd.reinit) h_r <= '{IV_A, IV_B, IV_C, IV_D};
      if (cmd.start) begin
        busy_r <= 1'b1;
        rnd_r <= '0;
      end else if (busy_r) begin
        // round counter parks on the last round until the chaining add
        if (rnd_r == 6'd63) busy_r <= 1'b0;
        else rnd_r <= rnd_r + 6'd1;
      end else if (done_r == 1'b0 && rnd_r == 6'd63) begin
        // final add in the cycle after the last round
        h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r; h_r[3] <= h_r[3] + d_r;
        done_r <= 1'b1;
        rnd_r <= '0;
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign digest = '{digest_a: h_r[0], digest_b: h_r[1], digest_c: h_r[2],
                    digest_d: h_r[3]};

endmodule
`default_nettype wire

// ===== verif/md5_digest_engine_core_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5_digest_engine_core_test
// Self-checking bench for the MD5 engine. A local digest calculator follows
// every accepted word and queues the digest each finish should give; results
// are compared field by field as they leave the block.
// ----------------------------------------------------------------------------
module md5_digest_engine_core_test;
  import md5_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  md5_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  md5_out_t out_data;

  // calculator state
  logic [31:0] chain [4];
  logic [7:0]  blk [64];
  int unsigned fill;
  logic [63:0] msg_bytes;

  md5_out_t digest_q [$];
  int       n_errors;
  int       n_digests;
  int       n_words;
  int       n_cycles;
  bit       drain_done;

  md5_digest_engine_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] rol(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  task automatic chain_reset();
    chain[0] = 32'h67452301;
    chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe;
    chain[3] = 32'h10325476;
    fill = 0;
    msg_bytes = '0;
  endtask

  task automatic compress();
    logic [31:0] k_tab [64];
    int          s_tab [16];
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int          g;
    k_tab = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    s_tab = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (b & d) | (c & ~d); g = (5*i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3*i + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7*i) % 16;
      end
      t = a + f + w[g] + k_tab[i];
      t = b + rol(t, s_tab[(i/16)*4 + i%4]);
      a = d; d = c; c = b; b = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic absorb_byte(input logic [7:0] v);
    blk[fill] = v;
    fill++;
    msg_bytes++;
    if (fill == BLOCK_BYTES) begin
      compress();
      fill = 0;
    end
  endtask

  task automatic close_message();
    logic [63:0] bits;
    int          n;
    md5_out_t    dg;
    bits = msg_bytes << 3;
    n = fill;
    blk[n++] = PAD_BYTE;
    if (n > LEN_OFFSET) begin
      while (n < BLOCK_BYTES) blk[n++] = 8'h00;
      compress();
      n = 0;
    end
    while (n < LEN_OFFSET) blk[n++] = 8'h00;
    for (int k = 0; k < 8; k++) blk[LEN_OFFSET + k] = bits[8*k +: 8];
    compress();
    dg = '{digest_a: chain[0], digest_b: chain[1], digest_c: chain[2],
           digest_d: chain[3]};
    digest_q.push_back(dg);
    chain_reset();
  endtask

  // one word into the calculator
  task automatic predict(input md5_in_t w);
    case (w.op)
      OP_ABSORB: absorb_byte(w.data_byte);
      OP_ABSORB_FINISH: begin
        absorb_byte(w.data_byte);
        close_message();
      end
      OP_FINISH: close_message();
      default: ;
    endcase
  endtask

  // valid stays high into the next word when no gap is drawn
  task automatic send_word(input logic [1:0] op, input logic [7:0] v);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: op, data_byte: v};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict('{op: op, data_byte: v});
    n_words++;
  endtask

  // result checker and receiver stalls
  initial begin
    int wait_n;
    md5_out_t exp_d;
    out_stall = 1'b1;
    wait_n = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $display("%0t unexpected digest %h", $time, out_data);
          n_errors++;
        end else begin
          exp_d = digest_q.pop_front();
          n_digests++;
          if (out_data.digest_a !== exp_d.digest_a) begin
            $display("%0t digest_a exp %h got %h", $time, exp_d.digest_a,
                     out_data.digest_a);
            n_errors++;
          end
          if (out_data.digest_b !== exp_d.digest_b) begin
            $display("%0t digest_b exp %h got %h", $time, exp_d.digest_b,
                     out_data.digest_b);
            n_errors++;
          end
          if (out_data.digest_c !== exp_d.digest_c) begin
            $display("%0t digest_c exp %h got %h", $time, exp_d.digest_c,
                     out_data.digest_c);
            n_errors++;
          end
          if (out_data.digest_d !== exp_d.digest_d) begin
            $display("%0t digest_d exp %h got %h", $time, exp_d.digest_d,
                     out_data.digest_d);
            n_errors++;
          end
        end
      end
      // stall pattern: a fresh wait is drawn per digest taken; some runs never stall
      if (wait_n > 0) begin
        wait_n--;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        wait_n = (n_words / 300) % 2 ? 0 : $urandom_range(0, 7);
        out_stall <= (wait_n > 0);
        if (wait_n > 0) wait_n--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    n_cycles = 0;
    forever begin
      @(posedge clk);
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", n_cycles);
        $display("[md5_digest_engine_core] ERROR");
        $finish;
      end
    end
  end

  task automatic send_message(input int len, input logic [1:0] close_op);
    for (int i = 0; i < len - 1; i++) send_word(OP_ABSORB, 8'($urandom));
    if (close_op == OP_ABSORB_FINISH) begin
      send_word(OP_ABSORB_FINISH, 8'($urandom));
    end else begin
      if (len > 0) send_word(OP_ABSORB, 8'($urandom));
      send_word(OP_FINISH, 8'($urandom));
    end
  endtask

  task automatic test_directed();
    send_word(OP_FINISH, 8'h00);              // empty message
    send_word(OP_ABSORB_FINISH, 8'hff);
    send_word(OP_ABSORB, 8'h00);
    send_word(2'd3, 8'hff);                   // unused opcode, dropped
    send_word(2'd3, 8'h00);
    send_word(OP_ABSORB, 8'haa);
    send_word(OP_ABSORB_FINISH, 8'h55);
    send_word(OP_FINISH, 8'hff);              // byte ignored on finish only
    send_word(OP_ABSORB, 8'h61);
    send_word(OP_ABSORB, 8'h62);
    send_word(OP_ABSORB, 8'h63);
    send_word(OP_FINISH, 8'h00);
  endtask

  // lengths around the padding boundaries and a whole block
  task automatic test_padding_edges();
    int lens [8];
    lens = '{55, 56, 57, 63, 64, 65, 119, 128};
    foreach (lens[i])
      send_message(lens[i], (i % 2) ? OP_ABSORB_FINISH : OP_FINISH);
  endtask

  task automatic test_random_messages();
    int len;
    int sent;
    sent = n_words;
    while (n_words - sent < 700) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(2'd3, 8'($urandom));
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 140)
                                          : $urandom_range(0, 20);
        send_message(len, $urandom_range(0, 1) ? OP_ABSORB_FINISH : OP_FINISH);
      end
    end
  endtask

  initial begin
    int hold;
    n_errors = 0;
    n_digests = 0;
    n_words = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    chain_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_padding_edges();
    test_random_messages();
    in_valid <= 1'b0;
    hold = 0;
    while (digest_q.size() != 0 && hold < 200000) begin
      @(posedge clk);
      hold++;
    end
    repeat (300) @(posedge clk);
    $display("%0d words sent, %0d digests checked, boundary and empty messages",
             n_words, n_digests);
    if (n_errors == 0 && digest_q.size() == 0) begin
      $display("[md5_digest_engine_core] OK");
    end else begin
      $display("%0d mismatches, %0d digests missing", n_errors, digest_q.size());
      $display("[md5_digest_engine_core] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/md5_pkg.sv
hw/rtl/md5_ctrl.sv
hw/rtl/md5_dp.sv
hw/rtl/md5_digest_engine_core.sv
verif/md5_digest_engine_core_test.sv
